// File: hdl/pohist_pkg.sv
package pohist_pkg;

  // Field widths fixed by the request and result formats
  localparam int unsigned POS_W   = 24;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CORDIC_STEPS = 30;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_BOX_LENGTH = 2'd0,
    CFG_BIN_WIDTH  = 2'd1
  } cfg_idx_t;

  typedef enum logic {
    MODE_ACCUM = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  typedef struct packed {
    logic             mode;
    logic [23:0]      tag_x;
    logic [23:0]      tag_y;
    logic [15:0]      tag_heading;
    logic [23:0]      other_x;
    logic [23:0]      other_y;
    logic [15:0]      other_heading;
    logic [4:0]       read_radial_bin;
    logic [6:0]       read_bearing_bin;
    logic [6:0]       read_heading_bin;
  } in_req_t;

  typedef struct packed {
    logic [31:0]      bin_count;
    logic             counted;
    logic [4:0]       radial_bin;
    logic [6:0]       bearing_bin;
    logic [6:0]       heading_bin;
  } out_res_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIFF,
    ST_WRAP_HI,
    ST_WRAP_LO,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT,
    ST_DIV,
    ST_RCHK,
    ST_CINIT,
    ST_CORDIC,
    ST_BINS,
    ST_IDX1,
    ST_IDX2,
    ST_MRD,
    ST_UPD,
    ST_OUT
  } state_t;

  // arctan(2^-i) in 1/2^32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000028;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000002;
      5'd29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// File: hdl/pair_orientation_histogram.sv
// Channel  | Ports                                  | Handshake
// request  | start, busy, in_data                   | taken when start & !busy
// result   | out_valid, out_data                    | one-cycle strobe, no back-pressure
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | written when valid & ready
//
// An accumulate request keeps busy high through 26 square-root, 26 divide and
// 30 CORDIC steps on one shared step counter, plus set-up and read-modify-write states;
// a coincident pair goes from the first squaring state straight to the result, and a pair
// beyond the last radial bin from the range check. A read request passes the index,
// memory-read and update states, or goes straight to the result when out of range. After
// reset a clearing pass writes zero to every bin, one per cycle, with busy high; results are never stalled.
module pair_orientation_histogram #(
  parameter int unsigned RADIAL_BINS  = 32,
  parameter int unsigned BEARING_BINS = 80,
  parameter int unsigned HEADING_BINS = 80,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pohist_pkg::in_req_t           in_data,
  output logic                          out_valid,
  output pohist_pkg::out_res_t          out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pohist_pkg::CIDX_W-1:0] cfg_index,
  input  logic [pohist_pkg::CFG_W-1:0]  cfg_data
);
  import pohist_pkg::*;

  localparam int unsigned DEPTH  = RADIAL_BINS * BEARING_BINS * HEADING_BINS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned RBW    = $clog2(RADIAL_BINS + 1);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CLIM = CMAX - COUNT_WIDTH'(2);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] box_r, width_r;
  in_req_t          req_r;
  logic             rd_ok_r;

  logic signed [25:0] dx_r, dy_r;
  logic [51:0]        sqx_r, sqy_r, rad_r;
  logic [28:0]        rem_r;
  logic [25:0]        root_r;
  logic [25:0]        quo_r;
  logic [23:0]        drem_r, div_r;
  logic signed [55:0] cx_r, cy_r;
  logic [31:0]        cz_r;
  logic [4:0]         step_r;

  logic [RBW-1:0]     rbin_r;
  logic [7:0]         bbin_r, hbin_r;
  logic [ADDR_W-1:0]  part_r, addr_r, clr_r;
  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_r;
  out_res_t           res_r;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_wa;
  logic [COUNT_WIDTH-1:0] mem_wd, cnt_new;
  logic                   accept, rd_in_range;

  assign accept    = start && (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign rd_in_range = (32'(in_data.read_radial_bin) < RADIAL_BINS) &&
                       (32'(in_data.read_bearing_bin) < BEARING_BINS) &&
                       (32'(in_data.read_heading_bin) < HEADING_BINS);
  assign cnt_new = (rd_r > CLIM) ? CMAX : rd_r + COUNT_WIDTH'(2);

  // Datapath combinational helpers
  logic signed [26:0] len_s, dx2, dy2;
  logic signed [25:0] len26;
  logic [28:0]        sq_cur, sq_cmp;
  logic [25:0]        root_new;
  logic [24:0]        dv_cur;
  logic signed [55:0] xs, ys;
  logic [15:0]        ang, rel, hrel;
  logic [23:0]        bprod, hprod;

  assign len_s  = signed'({3'b000, box_r});
  assign len26  = signed'({2'b00, box_r});
  assign dx2    = {dx_r, 1'b0};
  assign dy2    = {dy_r, 1'b0};
  assign sq_cur = {rem_r[26:0], rad_r[51:50]};
  assign sq_cmp = {1'b0, root_r, 2'b01};
  assign root_new = (sq_cur >= sq_cmp) ? {root_r[24:0], 1'b1} : {root_r[24:0], 1'b0};
  assign dv_cur = {drem_r, quo_r[25]};
  assign xs     = cx_r >>> step_r;
  assign ys     = cy_r >>> step_r;
  assign ang    = 16'((cz_r + 32'h0000_8000) >> 16);
  assign rel    = ang - req_r.tag_heading + 16'h8000;
  assign hrel   = req_r.other_heading - req_r.tag_heading;
  assign bprod  = 24'(rel) * 24'(BEARING_BINS);
  assign hprod  = 24'(hrel) * 24'(HEADING_BINS);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          if (in_data.mode == MODE_READ) state_nxt = rd_in_range ? ST_IDX1 : ST_OUT;
          else state_nxt = ST_DIFF;
        end
      end
      ST_DIFF:    state_nxt = ST_WRAP_HI;
      ST_WRAP_HI: state_nxt = ST_WRAP_LO;
      ST_WRAP_LO: state_nxt = ST_SQX;
      ST_SQX:     state_nxt = (dx_r == '0 && dy_r == '0) ? ST_OUT : ST_SQY;
      ST_SQY:     state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_SQRT;
      ST_SQRT:    if (step_r == 5'd25) state_nxt = ST_DIV;
      ST_DIV:     if (step_r == 5'd25) state_nxt = ST_RCHK;
      ST_RCHK:    state_nxt = (32'(quo_r) >= RADIAL_BINS) ? ST_OUT : ST_CINIT;
      ST_CINIT:   state_nxt = ST_CORDIC;
      ST_CORDIC:  if (step_r == 5'(CORDIC_STEPS - 1)) state_nxt = ST_BINS;
      ST_BINS:    state_nxt = ST_IDX1;
      ST_IDX1:    state_nxt = ST_IDX2;
      ST_IDX2:    state_nxt = ST_MRD;
      ST_MRD:     state_nxt = ST_UPD;
      ST_UPD:     state_nxt = ST_OUT;
      ST_OUT:     state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and memory write port
  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    out_data  = res_r;
    mem_we    = 1'b0;
    mem_wa    = addr_r;
    mem_wd    = cnt_new;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
      end
      ST_UPD:   mem_we = (req_r.mode == MODE_ACCUM);
      default:  mem_we = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      step_r  <= '0;
      box_r   <= CFG_W'(9183219);
      width_r <= CFG_W'(6554);
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + ADDR_W'(1);
      step_r  <= (state_nxt != state_r) ? 5'd0 : step_r + 5'd1;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BOX_LENGTH) box_r <= cfg_data;
        if (cfg_index == CFG_BIN_WIDTH)  width_r <= cfg_data;
      end
    end
  end

  // Histogram memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[addr_r];
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_r   <= in_data;
          rd_ok_r <= rd_in_range;
          rbin_r  <= RBW'(in_data.read_radial_bin);
          bbin_r  <= 8'(in_data.read_bearing_bin);
          hbin_r  <= 8'(in_data.read_heading_bin);
          res_r   <= '0;
          if (in_data.mode == MODE_READ) begin
            res_r.radial_bin  <= in_data.read_radial_bin;
            res_r.bearing_bin <= in_data.read_bearing_bin;
            res_r.heading_bin <= in_data.read_heading_bin;
          end
        end
      end
      ST_DIFF: begin
        dx_r <= signed'(26'(req_r.other_x)) - signed'(26'(req_r.tag_x));
        dy_r <= signed'(26'(req_r.other_y)) - signed'(26'(req_r.tag_y));
      end
      // Minimum image, upper then lower correction
      ST_WRAP_HI: begin
        if (dx2 > len_s) dx_r <= dx_r - len26;
        if (dy2 > len_s) dy_r <= dy_r - len26;
      end
      ST_WRAP_LO: begin
        if (dx2 <= -len_s) dx_r <= dx_r + len26;
        if (dy2 <= -len_s) dy_r <= dy_r + len26;
      end
      ST_SQX:  sqx_r <= unsigned'(52'(dx_r * dx_r));
      ST_SQY:  sqy_r <= unsigned'(52'(dy_r * dy_r));
      ST_SUM: begin
        rad_r  <= sqx_r + sqy_r;
        rem_r  <= '0;
        root_r <= '0;
      end
      // Restoring square root, two radicand bits a step
      ST_SQRT: begin
        rad_r  <= {rad_r[49:0], 2'b00};
        rem_r  <= (sq_cur >= sq_cmp) ? sq_cur - sq_cmp : sq_cur;
        root_r <= root_new;
        if (step_r == 5'd25) begin
          quo_r  <= root_new;
          drem_r <= '0;
          div_r  <= (width_r == '0) ? CFG_W'(1) : width_r;
        end
      end
      // Restoring division, one quotient bit a step
      ST_DIV: begin
        if (dv_cur >= {1'b0, div_r}) begin
          drem_r <= 24'(dv_cur - {1'b0, div_r});
          quo_r  <= {quo_r[24:0], 1'b1};
        end else begin
          drem_r <= dv_cur[23:0];
          quo_r  <= {quo_r[24:0], 1'b0};
        end
      end
      ST_RCHK: rbin_r <= quo_r[RBW-1:0];
      ST_CINIT: begin
        if (dx_r < 0) begin
          cx_r <= -(56'(dx_r) <<< 28);
          cy_r <= -(56'(dy_r) <<< 28);
          cz_r <= 32'h8000_0000;
        end else begin
          cx_r <= 56'(dx_r) <<< 28;
          cy_r <= 56'(dy_r) <<< 28;
          cz_r <= '0;
        end
      end
      // CORDIC vectoring, one rotation a step
      ST_CORDIC: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + atan_turn(step_r);
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - atan_turn(step_r);
        end
      end
      ST_BINS: begin
        bbin_r            <= bprod[23:16];
        hbin_r            <= hprod[23:16];
        res_r.radial_bin  <= 5'(rbin_r);
        res_r.bearing_bin <= 7'(bprod[23:16]);
        res_r.heading_bin <= 7'(hprod[23:16]);
      end
      ST_IDX1: part_r <= ADDR_W'(rbin_r) * ADDR_W'(BEARING_BINS) + ADDR_W'(bbin_r);
      ST_IDX2: addr_r <= part_r * ADDR_W'(HEADING_BINS) + ADDR_W'(hbin_r);
      ST_UPD: begin
        if (req_r.mode == MODE_READ) begin
          res_r.bin_count <= rd_ok_r ? 32'(rd_r) : '0;
        end else begin
          res_r.bin_count <= 32'(cnt_new);
          res_r.counted   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
